FILE: design/ttes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttes_pkg;

    localparam int NUM_TIMERS  = 32;
    localparam int TIMER_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int ID_W        = 5;
    localparam int TIME_W      = 64;
    localparam int MARGIN_W    = 32;

    typedef logic [TIMER_IDX_W-1:0] t_idx;

    localparam t_idx              LAST_IDX = t_idx'(NUM_TIMERS - 1);
    localparam logic [TIME_W-1:0] ALL_ONES = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_DEL  = 2'd1,
        OP_RUN  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_SET   = 2'd0,
        KIND_DEL   = 2'd1,
        KIND_FIRED = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET,
        S_DEL,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] new_expiry;
        logic [TIME_W-1:0] now_time;
    } t_in_item;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   slot;
        logic              unchanged;
        logic              reprogram;
        logic [TIME_W-1:0] next_deadline;
        logic              last;
    } t_out_item;

    // Control into the fired-slot queue.
    typedef struct packed {
        logic push;
        t_idx push_idx;
        logic pop;
    } t_fq_ctrl;

    // Status out of the fired-slot queue.
    typedef struct packed {
        logic nonempty;
        t_idx head;
    } t_fq_stat;

    function automatic t_idx id_to_idx(input logic [ID_W-1:0] id);
        logic [ID_W+TIMER_IDX_W-1:0] w;
        w = {{TIMER_IDX_W{1'b0}}, id};
        return w[TIMER_IDX_W-1:0];
    endfunction

    function automatic logic [ID_W-1:0] idx_to_id(input t_idx idx);
        logic [ID_W+TIMER_IDX_W-1:0] w;
        w = {{ID_W{1'b0}}, idx};
        return w[ID_W-1:0];
    endfunction

    function automatic logic id_in_range(input logic [ID_W-1:0] id);
        return (int'(id) < NUM_TIMERS);
    endfunction

endpackage

`default_nettype wire

FILE: design/timer_table_expiry_scan.sv
`timescale 1ns / 1ps
`default_nettype none

// Timer slot table with next-deadline tracking. Slot expiries live in a
// single-port-write, single-port-read RAM with a registered read; pending
// flags are flip-flops cleared by reset, so no clearing pass is needed.
// A set reads the RAM, then compares and writes back; a delete clears the
// pending flag of its slot, and an OP_NONE item returns straight to idle.
// A run scans every slot through the RAM read port, then issues one request
// per fired slot and one summary request. A stalled result holds the block
// in its current step. The next item is taken while the last result of the
// previous one still waits in the output register.
module timer_table_expiry_scan (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire ttes_pkg::t_in_item               i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output ttes_pkg::t_out_item                   o_out_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ttes_pkg::MARGIN_W-1:0]    i_cfg_data
);

    ttes_pkg::t_state                r_state;
    ttes_pkg::t_state                n_state;
    ttes_pkg::t_in_item              r_item;
    logic [ttes_pkg::TIME_W-1:0]     r_limit;
    logic [ttes_pkg::MARGIN_W-1:0]   r_margin;
    logic [ttes_pkg::TIME_W-1:0]     r_deadline;
    logic [ttes_pkg::TIME_W-1:0]     n_deadline;
    logic                            r_pending [ttes_pkg::NUM_TIMERS];
    ttes_pkg::t_idx                  r_idx;
    logic [ttes_pkg::TIME_W-1:0]     r_earliest;
    logic [ttes_pkg::TIME_W-1:0]     n_earliest;
    logic                            r_any_left;
    logic                            n_any_left;
    ttes_pkg::t_out_item             r_out;
    ttes_pkg::t_out_item             n_out;
    logic                            r_out_vld;

    logic                            in_take;
    logic                            out_free;
    logic                            out_load;
    ttes_pkg::t_idx                  item_idx;
    logic                            item_in_range;
    logic [ttes_pkg::TIME_W-1:0]     rdata;
    logic                            set_unch;
    logic                            set_write;
    logic                            set_lower;
    logic                            scan_pend;
    logic                            scan_fire;
    logic                            scan_keep;
    logic                            scan_last;
    logic                            dl_load;
    logic                            pend_we;
    ttes_pkg::t_idx                  pend_idx;
    logic                            pend_val;
    logic                            ram_we;
    ttes_pkg::t_idx                  ram_waddr;
    logic [ttes_pkg::TIME_W-1:0]     ram_wdata;
    ttes_pkg::t_idx                  ram_raddr;
    ttes_pkg::t_fq_ctrl              fq_ctrl;
    ttes_pkg::t_fq_stat              fq_stat;

    ttes_ram #(
        .WIDTH (ttes_pkg::TIME_W),
        .DEPTH (ttes_pkg::NUM_TIMERS)
    ) u_expiry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    ttes_fire_queue u_fire_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (fq_ctrl),
        .o_stat  (fq_stat)
    );

    assign o_in_stall  = (r_state != ttes_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign in_take       = i_in_valid && (r_state == ttes_pkg::S_IDLE);
    assign out_free      = !r_out_vld || !i_out_stall;
    assign item_idx      = ttes_pkg::id_to_idx(r_item.timer_id);
    assign item_in_range = ttes_pkg::id_in_range(r_item.timer_id);

    // Set: the stored expiry only counts while the slot is pending.
    assign set_unch  = item_in_range && r_pending[item_idx] && (rdata == r_item.new_expiry);
    assign set_write = item_in_range && !set_unch;
    assign set_lower = set_write &&
                       ((r_deadline == '0) || (r_deadline > r_item.new_expiry));

    assign scan_pend = r_pending[r_idx];
    assign scan_fire = scan_pend && (rdata <= r_limit);
    assign scan_keep = scan_pend && !scan_fire;
    assign scan_last = (r_idx == ttes_pkg::LAST_IDX);

    assign n_earliest = (scan_keep && (rdata < r_earliest)) ? rdata : r_earliest;
    assign n_any_left = r_any_left || scan_keep;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ttes_pkg::S_IDLE: begin
                if (in_take) begin
                    unique case (i_in_data.op)
                        ttes_pkg::OP_SET:  n_state = ttes_pkg::S_SET;
                        ttes_pkg::OP_DEL:  n_state = ttes_pkg::S_DEL;
                        ttes_pkg::OP_RUN:  n_state = ttes_pkg::S_SCAN;
                        ttes_pkg::OP_NONE: n_state = ttes_pkg::S_IDLE;
                    endcase
                end
            end
            ttes_pkg::S_SET, ttes_pkg::S_DEL: begin
                if (out_free) begin
                    n_state = ttes_pkg::S_IDLE;
                end
            end
            ttes_pkg::S_SCAN: begin
                if (scan_last) begin
                    n_state = ttes_pkg::S_EMIT;
                end
            end
            ttes_pkg::S_EMIT: begin
                if (out_free && !fq_stat.nonempty) begin
                    n_state = ttes_pkg::S_IDLE;
                end
            end
            default: n_state = ttes_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        out_load         = 1'b0;
        n_out            = '0;
        ram_we           = 1'b0;
        ram_waddr        = item_idx;
        ram_wdata        = r_item.new_expiry;
        ram_raddr        = item_idx;
        pend_we          = 1'b0;
        pend_idx         = item_idx;
        pend_val         = 1'b0;
        dl_load          = 1'b0;
        n_deadline       = r_deadline;
        fq_ctrl.push     = 1'b0;
        fq_ctrl.push_idx = r_idx;
        fq_ctrl.pop      = 1'b0;
        unique case (r_state)
            ttes_pkg::S_IDLE: begin
                ram_raddr = (i_in_data.op == ttes_pkg::OP_RUN) ? '0 :
                            ttes_pkg::id_to_idx(i_in_data.timer_id);
            end
            ttes_pkg::S_SET: begin
                if (out_free) begin
                    out_load = 1'b1;
                    ram_we   = set_write;
                    pend_we  = set_write;
                    pend_val = 1'b1;
                    if (set_lower) begin
                        dl_load    = 1'b1;
                        n_deadline = r_item.new_expiry;
                    end
                    n_out.kind          = ttes_pkg::KIND_SET;
                    n_out.slot          = r_item.timer_id;
                    n_out.unchanged     = set_unch;
                    n_out.reprogram     = set_lower;
                    n_out.next_deadline = set_lower ? r_item.new_expiry : r_deadline;
                    n_out.last          = 1'b1;
                end
            end
            ttes_pkg::S_DEL: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    pend_we             = item_in_range;
                    pend_val            = 1'b0;
                    n_out.kind          = ttes_pkg::KIND_DEL;
                    n_out.slot          = r_item.timer_id;
                    n_out.next_deadline = r_deadline;
                    n_out.last          = 1'b1;
                end
            end
            ttes_pkg::S_SCAN: begin
                // Read one slot ahead while the current one is written back.
                ram_raddr        = scan_last ? '0 : (r_idx + 1'b1);
                ram_we           = scan_fire;
                ram_waddr        = r_idx;
                ram_wdata        = ttes_pkg::ALL_ONES;
                pend_we          = scan_fire;
                pend_idx         = r_idx;
                pend_val         = 1'b0;
                fq_ctrl.push     = scan_fire;
                fq_ctrl.push_idx = r_idx;
                if (scan_last) begin
                    dl_load    = 1'b1;
                    n_deadline = n_any_left ? n_earliest : '0;
                end
            end
            ttes_pkg::S_EMIT: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    n_out.next_deadline = r_deadline;
                    if (fq_stat.nonempty) begin
                        fq_ctrl.pop = 1'b1;
                        n_out.kind  = ttes_pkg::KIND_FIRED;
                        n_out.slot  = ttes_pkg::idx_to_id(fq_stat.head);
                    end else begin
                        n_out.kind      = ttes_pkg::KIND_DONE;
                        n_out.reprogram = r_any_left;
                        n_out.last      = 1'b1;
                    end
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ttes_pkg::S_IDLE;
            r_margin   <= '0;
            r_deadline <= '0;
            r_idx      <= '0;
            r_any_left <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int i = 0; i < ttes_pkg::NUM_TIMERS; i++) begin
                r_pending[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_margin <= i_cfg_data;
            end
            if (dl_load) begin
                r_deadline <= n_deadline;
            end
            if (pend_we) begin
                r_pending[pend_idx] <= pend_val;
            end
            if (in_take) begin
                r_idx      <= '0;
                r_any_left <= 1'b0;
            end else if (r_state == ttes_pkg::S_SCAN) begin
                r_idx      <= r_idx + 1'b1;
                r_any_left <= n_any_left;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item     <= i_in_data;
            r_limit    <= i_in_data.now_time +
                          {{(ttes_pkg::TIME_W - ttes_pkg::MARGIN_W){1'b0}}, r_margin};
            r_earliest <= ttes_pkg::ALL_ONES;
        end else if (r_state == ttes_pkg::S_SCAN) begin
            r_earliest <= n_earliest;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    a_ram_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == ttes_pkg::S_SET) || (r_state == ttes_pkg::S_SCAN)))
        else $error("expiry RAM written outside a set or a scan");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttes_pkg::S_SCAN) |-> (r_idx <= ttes_pkg::LAST_IDX))
        else $error("scan index beyond the table");

    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (n_out.kind == ttes_pkg::KIND_DONE)) |-> !fq_stat.nonempty)
        else $error("run summary issued with fired slots still queued");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> r_out_vld)
        else $error("stalled result request dropped");

    a_emit_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ttes_pkg::S_SCAN) |-> !fq_ctrl.push)
        else $error("fired slot queued outside the scan");

endmodule

`default_nettype wire

FILE: design/ttes_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ttes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/ttes_fire_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ttes_fire_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ttes_pkg::t_fq_ctrl i_ctrl,
    output ttes_pkg::t_fq_stat      o_stat
);

    logic [ttes_pkg::NUM_TIMERS-1:0] r_mask;
    logic [ttes_pkg::NUM_TIMERS-1:0] n_mask;
    logic [ttes_pkg::NUM_TIMERS-1:0] push_bit;
    logic [ttes_pkg::NUM_TIMERS-1:0] low_bit;
    ttes_pkg::t_idx                  head;

    // The lowest set bit is the lowest fired slot, so slots leave in index order.
    always_comb begin
        low_bit  = r_mask & (~r_mask + 1'b1);
        head     = '0;
        push_bit = '0;
        for (int i = 0; i < ttes_pkg::NUM_TIMERS; i++) begin
            if (low_bit[i]) begin
                head = head | ttes_pkg::TIMER_IDX_W'(i);
            end
            if (i_ctrl.push && (i_ctrl.push_idx == ttes_pkg::TIMER_IDX_W'(i))) begin
                push_bit[i] = 1'b1;
            end
        end
        n_mask = (r_mask | push_bit) & ~(i_ctrl.pop ? low_bit : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    assign o_stat.nonempty = |r_mask;
    assign o_stat.head     = head;

endmodule

`default_nettype wire

FILE: dv/timer_table_expiry_scan_test.sv
`timescale 1ns / 1ps

module timer_table_expiry_scan_test;

    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = ttes_pkg::NUM_TIMERS + 8;
    localparam int MAX_CYCLES  = 400000;
    localparam int IDLE_PCT    = 38;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    ttes_pkg::t_in_item            i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    ttes_pkg::t_out_item           o_out_data;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [ttes_pkg::MARGIN_W-1:0] i_cfg_data  = '0;

    // Requests waiting to be offered, and reports the table still owes.
    ttes_pkg::t_in_item  timer_requests[$];
    ttes_pkg::t_out_item timer_reports_due[$];

    // Mirror of the timer table.
    bit                            armed[ttes_pkg::NUM_TIMERS];
    logic [ttes_pkg::TIME_W-1:0]   expiry_of[ttes_pkg::NUM_TIMERS];
    logic [ttes_pkg::TIME_W-1:0]   programmed_deadline;
    logic [ttes_pkg::MARGIN_W-1:0] margin_now;

    // Last expiry handed to each slot by the generator, used to provoke re-arms.
    logic [ttes_pkg::TIME_W-1:0] planned_expiry[ttes_pkg::NUM_TIMERS];

    bit no_idle   = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int fail_count  = 0;
    int cycle_count = 0;

    timer_table_expiry_scan DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    task automatic update_timer_table(input ttes_pkg::t_in_item req);
        ttes_pkg::t_out_item         rep;
        logic [ttes_pkg::TIME_W-1:0] lim;
        logic [ttes_pkg::TIME_W-1:0] earliest;
        bit                          left;
        int                          fired[$];
        rep = '0;
        case (req.op)
            ttes_pkg::OP_SET: begin
                rep.kind = ttes_pkg::KIND_SET;
                rep.slot = req.timer_id;
                if (int'(req.timer_id) < ttes_pkg::NUM_TIMERS) begin
                    if (armed[req.timer_id] && expiry_of[req.timer_id] == req.new_expiry) begin
                        rep.unchanged = 1'b1;
                    end else begin
                        armed[req.timer_id]     = 1'b1;
                        expiry_of[req.timer_id] = req.new_expiry;
                        if (programmed_deadline == '0 ||
                            programmed_deadline > req.new_expiry) begin
                            programmed_deadline = req.new_expiry;
                            rep.reprogram       = 1'b1;
                        end
                    end
                end
                rep.next_deadline = programmed_deadline;
                rep.last          = 1'b1;
                timer_reports_due.push_back(rep);
            end
            ttes_pkg::OP_DEL: begin
                if (int'(req.timer_id) < ttes_pkg::NUM_TIMERS) begin
                    armed[req.timer_id] = 1'b0;
                end
                rep.kind          = ttes_pkg::KIND_DEL;
                rep.slot          = req.timer_id;
                rep.next_deadline = programmed_deadline;
                rep.last          = 1'b1;
                timer_reports_due.push_back(rep);
            end
            ttes_pkg::OP_RUN: begin
                lim      = req.now_time +
                           {{(ttes_pkg::TIME_W-ttes_pkg::MARGIN_W){1'b0}}, margin_now};
                earliest = ttes_pkg::ALL_ONES;
                left     = 1'b0;
                for (int i = 0; i < ttes_pkg::NUM_TIMERS; i++) begin
                    if (armed[i]) begin
                        if (expiry_of[i] <= lim) begin
                            armed[i]     = 1'b0;
                            expiry_of[i] = ttes_pkg::ALL_ONES;
                            fired.push_back(i);
                        end else begin
                            left = 1'b1;
                            if (expiry_of[i] < earliest) begin
                                earliest = expiry_of[i];
                            end
                        end
                    end
                end
                programmed_deadline = left ? earliest : '0;
                foreach (fired[j]) begin
                    rep               = '0;
                    rep.kind          = ttes_pkg::KIND_FIRED;
                    rep.slot          = ttes_pkg::ID_W'(fired[j]);
                    rep.next_deadline = programmed_deadline;
                    timer_reports_due.push_back(rep);
                end
                rep               = '0;
                rep.kind          = ttes_pkg::KIND_DONE;
                rep.reprogram     = left;
                rep.next_deadline = programmed_deadline;
                rep.last          = 1'b1;
                timer_reports_due.push_back(rep);
            end
            default: begin
            end
        endcase
    endtask

    // Request driver: a new request is only put up once the previous one has gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (timer_requests.size() != 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= timer_requests.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Report side back-pressure, with one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
        end else if (hold_req && !hold_done) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Reports are checked before the request of the same edge is modelled.
    always @(posedge i_clk) begin : report_check
        ttes_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (timer_reports_due.size() == 0) begin
                    $error("unexpected report: %p", o_out_data);
                    fail_count++;
                end else begin
                    want = timer_reports_due.pop_front();
                    if (o_out_data.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, o_out_data.kind);
                        fail_count++;
                    end
                    if (o_out_data.slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, o_out_data.slot);
                        fail_count++;
                    end
                    if (o_out_data.unchanged !== want.unchanged) begin
                        $error("unchanged: expected %0b, got %0b",
                               want.unchanged, o_out_data.unchanged);
                        fail_count++;
                    end
                    if (o_out_data.reprogram !== want.reprogram) begin
                        $error("reprogram: expected %0b, got %0b",
                               want.reprogram, o_out_data.reprogram);
                        fail_count++;
                    end
                    if (o_out_data.next_deadline !== want.next_deadline) begin
                        $error("next_deadline: expected %h, got %h",
                               want.next_deadline, o_out_data.next_deadline);
                        fail_count++;
                    end
                    if (o_out_data.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_out_data.last);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                update_timer_table(i_in_data);
            end
        end
    end

    task automatic push_req(input ttes_pkg::t_op op,
                            input logic [ttes_pkg::ID_W-1:0] id,
                            input logic [ttes_pkg::TIME_W-1:0] x,
                            input logic [ttes_pkg::TIME_W-1:0] t);
        ttes_pkg::t_in_item req;
        req.op         = op;
        req.timer_id   = id;
        req.new_expiry = x;
        req.now_time   = t;
        timer_requests.push_back(req);
        if (op == ttes_pkg::OP_SET) begin
            planned_expiry[id] = x;
        end
    endtask

    function automatic logic [ttes_pkg::TIME_W-1:0] pick_time();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return ttes_pkg::ALL_ONES - ttes_pkg::TIME_W'($urandom_range(1000));
        end
        return {$urandom, $urandom};
    endfunction

    // Waits until the table has answered everything, then lets a scan finish.
    task automatic wait_for_idle_table();
        do begin
            @(negedge i_clk);
        end while (timer_requests.size() != 0 || i_in_valid ||
                   timer_reports_due.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_margin(input logic [ttes_pkg::MARGIN_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        margin_now = value;
        @(negedge i_clk);
    endtask

    // Mostly arm-then-scan sequences around one point in time, with some noise.
    task automatic queue_random_requests(input int count);
        int                          made;
        int                          n;
        int                          r;
        logic [ttes_pkg::ID_W-1:0]   id;
        logic [ttes_pkg::TIME_W-1:0] base;
        made = 0;
        while (made < count) begin
            if ($urandom_range(99) < 75) begin
                base = pick_time();
                n    = ($urandom_range(9) == 0) ? ttes_pkg::NUM_TIMERS : $urandom_range(1, 6);
                for (int k = 0; k < n; k++) begin
                    id = ttes_pkg::ID_W'($urandom_range(ttes_pkg::NUM_TIMERS - 1));
                    r  = $urandom_range(9);
                    if (r < 7) begin
                        push_req(ttes_pkg::OP_SET, id,
                                 base + ttes_pkg::TIME_W'($urandom_range(400)),
                                 {$urandom, $urandom});
                    end else if (r == 7) begin
                        push_req(ttes_pkg::OP_SET, id, planned_expiry[id],
                                 {$urandom, $urandom});
                    end else begin
                        push_req(ttes_pkg::OP_DEL, id, {$urandom, $urandom},
                                 {$urandom, $urandom});
                    end
                end
                push_req(ttes_pkg::OP_RUN, ttes_pkg::ID_W'($urandom), {$urandom, $urandom},
                         base + ttes_pkg::TIME_W'($urandom_range(400)));
                made += n + 1;
            end else begin
                r = $urandom_range(3);
                push_req(ttes_pkg::t_op'(r), ttes_pkg::ID_W'($urandom), pick_time(),
                         pick_time());
                if (ttes_pkg::t_op'(r) != ttes_pkg::OP_NONE) begin
                    made++;
                end
            end
        end
    endtask

    initial begin
        while (cycle_count < MAX_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        programmed_deadline = '0;
        margin_now          = '0;
        foreach (armed[i]) begin
            armed[i]          = 1'b0;
            expiry_of[i]      = '0;
            planned_expiry[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_margin('0);
        push_req(ttes_pkg::OP_RUN, 5'd0, '0, '0);
        push_req(ttes_pkg::OP_SET, 5'd0, 64'd100, '0);
        push_req(ttes_pkg::OP_SET, 5'd0, 64'd100, '0);
        push_req(ttes_pkg::OP_SET, 5'd31, ttes_pkg::ALL_ONES, '0);
        // An expiry of zero lowers the deadline to the value that also means none.
        push_req(ttes_pkg::OP_SET, 5'd5, '0, '0);
        push_req(ttes_pkg::OP_SET, 5'd6, 64'd50, '0);
        push_req(ttes_pkg::OP_DEL, 5'd6, '0, '0);
        push_req(ttes_pkg::OP_DEL, 5'd7, ttes_pkg::ALL_ONES, ttes_pkg::ALL_ONES);
        push_req(ttes_pkg::OP_RUN, 5'd0, '0, 64'd99);
        // Slot 31 stays armed at all ones, which is a real deadline.
        push_req(ttes_pkg::OP_RUN, 5'd0, '0, ttes_pkg::ALL_ONES - 64'd1);
        push_req(ttes_pkg::OP_RUN, 5'd31, ttes_pkg::ALL_ONES, ttes_pkg::ALL_ONES);
        push_req(ttes_pkg::OP_SET, 5'd31, ttes_pkg::ALL_ONES, '0);
        push_req(ttes_pkg::OP_NONE, 5'd31, ttes_pkg::ALL_ONES, ttes_pkg::ALL_ONES);
        push_req(ttes_pkg::OP_SET, 5'd10, 64'h8000_0000_0000_0000, '0);
        wait_for_idle_table();

        write_margin({ttes_pkg::MARGIN_W{1'b1}});
        push_req(ttes_pkg::OP_SET, 5'd2, ttes_pkg::ALL_ONES - 64'd1, '0);
        push_req(ttes_pkg::OP_SET, 5'd3, 64'd5, '0);
        // The margin pushes the limit past the top of the range and it wraps.
        push_req(ttes_pkg::OP_RUN, 5'd0, '0, ttes_pkg::ALL_ONES - 64'd5);
        push_req(ttes_pkg::OP_RUN, 5'd0, '0, 64'h7FFF_FFFF_0000_0001);
        push_req(ttes_pkg::OP_RUN, 5'd0, '0, ttes_pkg::ALL_ONES);
        push_req(ttes_pkg::OP_NONE, 5'd0, '0, '0);
        queue_random_requests(70);
        wait_for_idle_table();

        write_margin(ttes_pkg::MARGIN_W'($urandom));
        queue_random_requests(70);
        wait_for_idle_table();

        write_margin(32'd1000);
        no_idle = 1'b1;
        queue_random_requests(70);
        wait_for_idle_table();
        no_idle = 1'b0;

        // Fill every slot and scan repeatedly while the report side is held off.
        hold_req = 1'b1;
        for (int i = 0; i < ttes_pkg::NUM_TIMERS; i++) begin
            push_req(ttes_pkg::OP_SET, ttes_pkg::ID_W'(i),
                     64'd5000 + ttes_pkg::TIME_W'(i), '0);
        end
        push_req(ttes_pkg::OP_RUN, 5'd0, '0, ttes_pkg::ALL_ONES);
        for (int i = 0; i < ttes_pkg::NUM_TIMERS; i++) begin
            push_req(ttes_pkg::OP_SET, ttes_pkg::ID_W'(i), {$urandom, $urandom}, '0);
        end
        push_req(ttes_pkg::OP_RUN, 5'd0, '0, {$urandom, $urandom});
        push_req(ttes_pkg::OP_RUN, 5'd0, '0, ttes_pkg::ALL_ONES);
        wait_for_idle_table();

        write_margin('0);
        queue_random_requests(70);
        wait_for_idle_table();

        write_margin(ttes_pkg::MARGIN_W'($urandom_range(1, 15)));
        queue_random_requests(70);
        wait_for_idle_table();

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
